// ===== design/atcl_pkg.sv =====
// Package for the AT command line collector: character codes, queue op types,
// front and back state types. No dependencies.
package atcl_pkg;

	localparam int LINE_MAX_DEF = 64;
	localparam int LEN_W        = 7;
	localparam int CHAR_W       = 8;
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = $clog2(Q_DEPTH);

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_DEL   = 8'h14;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_GOT_A,
		PH_COLLECT
	} phase_t;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_DELETE,
		OP_EMIT
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [CHAR_W-1:0] ch;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_LOAD
	} bstate_t;

endpackage

// ===== design/at_command_line_collector.sv =====
// AT command line collector. Input bytes are taken one per cycle while the
// 4-entry op queue has room; after a carriage return is accepted, its line is
// read out one word per cycle, while the output word is free, from the line store's read port.
// An empty command gives a single word.
// Reset (arst_n low) clears phase, queue, line length and output valid; the
// line store itself is not cleared.
module at_command_line_collector #(
	parameter int LINE_MAX = atcl_pkg::LINE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] cmd_char, [14:8] cmd_length, [15] zero
	output logic        m_tuser,   // char_present
	output logic        m_tlast    // last_of_line
);
	import atcl_pkg::*;

	q_status_t         q_st;
	op_t               push_op, head;
	logic              push, pop;
	logic [CHAR_W-1:0] out_char;
	logic [LEN_W-1:0]  out_len;

	atcl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_st     (q_st),
		.push     (push),
		.push_op  (push_op)
	);

	atcl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.st      (q_st)
	);

	atcl_back #(
		.LINE_MAX (LINE_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_st        (q_st),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_char    (out_char),
		.out_present (m_tuser),
		.out_len     (out_len),
		.out_last    (m_tlast)
	);

	assign m_tdata = {1'b0, out_len, out_char};

	a_q_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_st.full && q_st.empty))
		else $error("queue reports full and empty");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && out_len == '0 && out_char == '0)
		else $error("empty command word malformed");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> out_len != '0 && out_len <= LEN_W'(LINE_MAX))
		else $error("command length out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_st.empty)
		else $error("pop from empty queue");

endmodule

// ===== design/atcl_front.sv =====
// Front end: folds case, tracks the AT prefix and turns collected bytes into
// store / delete / emit ops for the queue. Depends on atcl_pkg.
module atcl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,    // [7:0] in_byte
	input  atcl_pkg::q_status_t q_st,
	output logic               push,
	output atcl_pkg::op_t      push_op
);
	import atcl_pkg::*;

	phase_t            phase_q, phase_d;
	logic [CHAR_W-1:0] c;
	logic              acc;

	always_comb begin
		if (s_tdata >= CH_LO_A && s_tdata <= CH_LO_Z) begin
			c = s_tdata - CASE_OFS;
		end else begin
			c = s_tdata;
		end
	end

	assign s_tready = !q_st.full;
	assign acc      = s_tvalid && s_tready;

	// next state
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			case (phase_q)
				PH_GOT_A: begin
					phase_d = (c == CH_T) ? PH_COLLECT : PH_HUNT;
				end
				PH_COLLECT: begin
					if (c == CH_CR) phase_d = PH_HUNT;
				end
				default: begin
					phase_d = (c == CH_A) ? PH_GOT_A : PH_HUNT;
				end
			endcase
		end
	end

	// op generation
	always_comb begin
		push         = 1'b0;
		push_op.kind = OP_STORE;
		push_op.ch   = c;
		if (acc) begin
			case (phase_q)
				PH_COLLECT: begin
					push = 1'b1;
					if (c == CH_BS || c == CH_DEL) begin
						push_op.kind = OP_DELETE;
					end else if (c == CH_CR) begin
						push_op.kind = OP_EMIT;
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

// ===== design/atcl_fifo.sv =====
// Small op queue between front and back ends.
// Depends on atcl_pkg.
module atcl_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  atcl_pkg::op_t       push_op,
	input  logic                pop,
	output atcl_pkg::op_t       head,
	output atcl_pkg::q_status_t st
);
	import atcl_pkg::*;

	op_t             slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push, do_pop;

	assign st.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign head     = slot_q[rd_ptr_q];
	assign do_push  = push && !st.full;
	assign do_pop   = pop && !st.empty;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/atcl_back.sv =====
// Back end: owns the line store and its length, executes queued ops and reads
// the line out through a registered output word. Depends on atcl_pkg.
module atcl_back #(
	parameter int LINE_MAX = atcl_pkg::LINE_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  atcl_pkg::op_t              head,
	input  atcl_pkg::q_status_t        q_st,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [atcl_pkg::CHAR_W-1:0] out_char,
	output logic                       out_present,
	output logic [atcl_pkg::LEN_W-1:0] out_len,
	output logic                       out_last
);
	import atcl_pkg::*;

	localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

	logic [CHAR_W-1:0] mem [LINE_MAX];
	logic [CHAR_W-1:0] rdata_q;

	bstate_t           state_q, state_d;
	logic [LEN_W-1:0]  len_q, len_d, emit_len_q, emit_len_d, cnt_q, cnt_d;
	logic              wr_en, rd_en, load, out_free, last_char;
	logic [AW-1:0]     raddr;
	logic [CHAR_W-1:0] ld_char;
	logic              ld_present, ld_last;
	logic [LEN_W-1:0]  ld_len;

	logic              out_valid_q, out_present_q, out_last_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [LEN_W-1:0]  out_len_q;

	assign out_free  = !out_valid_q || out_ready;
	assign last_char = ((cnt_q + LEN_W'(1)) == emit_len_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_st.empty && head.kind == OP_EMIT && len_q != '0) state_d = B_READ;
			end
			B_READ: begin
				state_d = B_LOAD;
			end
			B_LOAD: begin
				if (out_free && last_char) state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// datapath control
	always_comb begin
		pop        = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		raddr      = '0;
		len_d      = len_q;
		emit_len_d = emit_len_q;
		cnt_d      = cnt_q;
		load       = 1'b0;
		ld_char    = '0;
		ld_present = 1'b0;
		ld_len     = '0;
		ld_last    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_st.empty) begin
					case (head.kind)
						OP_STORE: begin
							pop = 1'b1;
							// full line: byte dropped
							if (len_q < LEN_W'(LINE_MAX)) begin
								wr_en = 1'b1;
								len_d = len_q + LEN_W'(1);
							end
						end
						OP_DELETE: begin
							pop = 1'b1;
							if (len_q != '0) len_d = len_q - LEN_W'(1);
						end
						OP_EMIT: begin
							if (len_q == '0) begin
								// empty command: single flagged word
								if (out_free) begin
									pop     = 1'b1;
									load    = 1'b1;
									ld_last = 1'b1;
								end
							end else begin
								pop        = 1'b1;
								rd_en      = 1'b1;
								emit_len_d = len_q;
								cnt_d      = '0;
								len_d      = '0;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			B_LOAD: begin
				if (out_free) begin
					load       = 1'b1;
					ld_char    = rdata_q;
					ld_present = 1'b1;
					ld_len     = emit_len_q;
					ld_last    = last_char;
					if (!last_char) begin
						cnt_d = cnt_q + LEN_W'(1);
						rd_en = 1'b1;
						raddr = cnt_d[AW-1:0];
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[len_q[AW-1:0]] <= head.ch;
		if (rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q    <= ld_char;
			out_present_q <= ld_present;
			out_len_q     <= ld_len;
			out_last_q    <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			len_q       <= '0;
			emit_len_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			len_q      <= len_d;
			emit_len_q <= emit_len_d;
			cnt_q      <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign out_present = out_present_q;
	assign out_len     = out_len_q;
	assign out_last    = out_last_q;

endmodule
